// File: hdl/vca_pkg.sv
// ----------------------------------------------------------------------------
// vca_pkg
// Shared types and constants of the voice channel allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package vca_pkg;

   localparam logic        OP_START   = 1'b0;
   localparam logic        OP_STOP    = 1'b1;
   localparam logic [3:0]  SUB_NONE   = 4'h0;
   localparam logic [3:0]  SUB_ANY    = 4'hF;
   localparam logic [31:0] LIFE_START = 32'h7fff_ffff;

   typedef struct packed {
      logic        opcode;
      logic [15:0] entity;
      logic [3:0]  sub_channel;
      logic [29:0] now;
      logic [23:0] sound_length;
   } request_type;

   typedef struct packed {
      logic        valid;
      logic        done;
      logic        has_pick;
      logic [31:0] best;
   } scan_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] end_time;
   } commit_type;

endpackage

`default_nettype wire

// File: hdl/vca_cell.sv
// ----------------------------------------------------------------------------
// vca_cell
// One channel of the table; folds its channel into the scan record in transit.
// ----------------------------------------------------------------------------
`default_nettype none

module vca_cell #(
   parameter int IDX_W      = 3,
   parameter int CNT_W      = 4,
   parameter int CELL_INDEX = 0
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire  [15:0]             viewer,
   input  vca_pkg::request_type    req,
   input  vca_pkg::scan_type       scan_in,
   input  wire  [IDX_W-1:0]        pick_in,
   input  wire  [CNT_W-1:0]        count_in,
   output vca_pkg::scan_type       scan_out,
   output logic [IDX_W-1:0]        pick_out,
   output logic [CNT_W-1:0]        count_out,
   input  vca_pkg::commit_type     commit,
   input  wire  [IDX_W-1:0]        commit_pick
);

   localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(CELL_INDEX);

   logic [15:0]       owner_ff;
   logic [3:0]        sub_ff;
   logic [31:0]       end_ff;
   logic              active_ff;

   vca_pkg::scan_type scan_ff, scan_in_nxt;
   logic [IDX_W-1:0]  pick_ff, pick_in_nxt;
   logic [CNT_W-1:0]  count_ff, count_in_nxt;

   logic              owner_match;
   logic              start_hit;
   logic              stop_hit;
   logic              protect;
   logic [31:0]       life;
   logic              clear;

   assign owner_match = (owner_ff == req.entity);
   assign start_hit   = (req.sub_channel != vca_pkg::SUB_NONE) && owner_match &&
                        ((sub_ff == req.sub_channel) || (req.sub_channel == vca_pkg::SUB_ANY));
   assign stop_hit    = owner_match &&
                        ((req.sub_channel == vca_pkg::SUB_NONE) || (sub_ff == req.sub_channel));
   assign protect     = (owner_ff == viewer) && (req.entity != viewer) && active_ff;
   assign life        = end_ff - {2'b00, req.now};

   always_comb begin
      scan_in_nxt  = scan_in;
      pick_in_nxt  = pick_in;
      count_in_nxt = count_in;
      clear        = 1'b0;
      if (scan_in.valid && !scan_in.done) begin
         if (req.opcode == vca_pkg::OP_START) begin
            if (start_hit) begin
               scan_in_nxt.done     = 1'b1;
               scan_in_nxt.has_pick = 1'b1;
               pick_in_nxt          = MY_INDEX;
            end else if (!protect && ($signed(life) < $signed(scan_in.best))) begin
               scan_in_nxt.best     = life;
               scan_in_nxt.has_pick = 1'b1;
               pick_in_nxt          = MY_INDEX;
            end
         end else if (stop_hit) begin
            clear        = 1'b1;
            count_in_nxt = count_in + CNT_W'(1);
            if (req.sub_channel != vca_pkg::SUB_NONE) begin
               scan_in_nxt.done = 1'b1;
            end
         end
      end
   end

   // advance the scan record one cell per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else begin
         scan_ff <= scan_in_nxt;
      end
      pick_ff  <= pick_in_nxt;
      count_ff <= count_in_nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_ff  <= '0;
         sub_ff    <= '0;
         end_ff    <= '0;
         active_ff <= 1'b0;
      end else if (clear) begin
         end_ff    <= '0;
         active_ff <= 1'b0;
      end else if (commit.valid && (commit_pick == MY_INDEX)) begin
         owner_ff  <= req.entity;
         sub_ff    <= req.sub_channel;
         end_ff    <= commit.end_time;
         active_ff <= 1'b1;
      end
   end

   assign scan_out  = scan_ff;
   assign pick_out  = pick_ff;
   assign count_out = count_ff;

endmodule

`default_nettype wire

// File: hdl/voice_channel_allocator.sv
// ----------------------------------------------------------------------------
// voice_channel_allocator
// Start and stop of mixer voices over a row of channel cells.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tuser opcode, tdata request fields
//  rsp     | out | rsp_tvalid/tready    | tuser granted, tdata index, count
//  csr     | in  | csr_we               | csr_wdata viewer entity
//
//  An item passes through accept, launch, the walk of the scan record along
//  the chain of cells, then the write-back.
//  Reset clears every channel and the viewer register at once.
//  A result waiting on rsp_tready holds the block in write-back; the next
//  transfer on req is taken once the result is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module voice_channel_allocator #(
   parameter int DYNAMIC_CHANNELS = 8
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [79:0] req_tdata,   // entity, sub_channel, now, sound_length, zero pad
   input  wire         req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // channel_index, stopped_count, zero pad
   output logic        rsp_tuser,   // granted
   input  wire         csr_we,
   input  wire  [15:0] csr_wdata
);

   localparam int IDX_W = $clog2(DYNAMIC_CHANNELS);
   localparam int CNT_W = $clog2(DYNAMIC_CHANNELS + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LAUNCH = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   vca_pkg::request_type req_ff;
   logic [15:0]          viewer_ff;

   vca_pkg::scan_type    link [0:DYNAMIC_CHANNELS];
   logic [IDX_W-1:0]     pick_link [0:DYNAMIC_CHANNELS];
   logic [CNT_W-1:0]     count_link [0:DYNAMIC_CHANNELS];

   logic                 fin_has_pick_ff;
   logic [IDX_W-1:0]     fin_pick_ff;
   logic [CNT_W-1:0]     fin_count_ff;

   logic                 rsp_valid_ff;
   logic [7:0]           rsp_data_ff;
   logic                 rsp_user_ff;

   vca_pkg::commit_type  commit;
   logic                 finish;
   logic                 is_start;
   logic [IDX_W+2:0]     index_wide;
   logic [CNT_W+3:0]     count_wide;

   assign req_tready = (state_ff == ST_IDLE);
   assign is_start   = (req_ff.opcode == vca_pkg::OP_START);
   assign finish     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   assign link[0]       = '{valid: (state_ff == ST_LAUNCH), done: 1'b0, has_pick: 1'b0,
                            best: vca_pkg::LIFE_START};
   assign pick_link[0]  = '0;
   assign count_link[0] = '0;

   assign commit.valid    = finish && is_start && fin_has_pick_ff;
   assign commit.end_time = {2'b00, req_ff.now} + {8'h00, req_ff.sound_length};

   for (genvar g = 0; g < DYNAMIC_CHANNELS; g++) begin : g_cell
      vca_cell #(
         .IDX_W      (IDX_W),
         .CNT_W      (CNT_W),
         .CELL_INDEX (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .viewer      (viewer_ff),
         .req         (req_ff),
         .scan_in     (link[g]),
         .pick_in     (pick_link[g]),
         .count_in    (count_link[g]),
         .scan_out    (link[g+1]),
         .pick_out    (pick_link[g+1]),
         .count_out   (count_link[g+1]),
         .commit      (commit),
         .commit_pick (fin_pick_ff)
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_SCAN;
         ST_SCAN:   if (link[DYNAMIC_CHANNELS].valid) state_in = ST_DONE;
         ST_DONE:   if (finish) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         viewer_ff <= '0;
      end else if (csr_we) begin
         viewer_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff.opcode       <= req_tuser;
         req_ff.entity       <= req_tdata[15:0];
         req_ff.sub_channel  <= req_tdata[19:16];
         req_ff.now          <= req_tdata[49:20];
         req_ff.sound_length <= req_tdata[73:50];
      end
   end

   // hold the end of the scan until the result register frees up
   always_ff @(posedge clock) begin
      if ((state_ff == ST_SCAN) && link[DYNAMIC_CHANNELS].valid) begin
         fin_has_pick_ff <= link[DYNAMIC_CHANNELS].has_pick;
         fin_pick_ff     <= pick_link[DYNAMIC_CHANNELS];
         fin_count_ff    <= count_link[DYNAMIC_CHANNELS];
      end
   end

   assign index_wide = fin_has_pick_ff ? {3'b000, fin_pick_ff} : '0;
   assign count_wide = is_start ? '0 : {4'h0, fin_count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_user_ff <= is_start && fin_has_pick_ff;
         rsp_data_ff <= {1'b0, count_wide[3:0], index_wide[2:0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_last_in_scan: assert property (@(posedge clock) disable iff (reset)
      link[DYNAMIC_CHANNELS].valid |-> (state_ff == ST_SCAN))
      else $error("scan record left the chain outside the scan state");

   a_launch_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAUNCH) |=> (state_ff == ST_SCAN))
      else $error("launch not followed by scan");

   a_commit_pick: assert property (@(posedge clock) disable iff (reset)
      commit.valid |-> (fin_has_pick_ff && (state_ff == ST_DONE)))
      else $error("write-back without a picked channel");

   a_grant_no_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[6:3] == 4'h0))
      else $error("granted result carries a stop count");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the voice channel allocator. Start and stop
// requests go in over the req stream; a local copy of the channel table
// predicts every grant, channel index and stop count, and each rsp transfer
// is compared with the oldest prediction. Directed cases cover the field
// extremes, viewer protection, a full table with no grant, wildcard and
// same-owner takeover, and both kinds of stop. Random phases follow under
// several viewer settings, with bursts of idling on both sides.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int NUM_CHANNELS  = 8;
   localparam int SCAN_LATENCY  = NUM_CHANNELS + 3;

   typedef struct {
      logic       granted;
      logic [2:0] index;
      logic [3:0] count;
   } voice_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata  = '0;  // entity, sub_channel, now, sound_length, zero pad
   logic        req_tuser  = 1'b0; // opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // channel_index, stopped_count, zero pad
   logic        rsp_tuser;         // granted
   logic        csr_we     = 1'b0;
   logic [15:0] csr_wdata  = '0;

   // channel table copy
   logic [15:0] chan_owner  [NUM_CHANNELS];
   logic [3:0]  chan_sub    [NUM_CHANNELS];
   logic [31:0] chan_end    [NUM_CHANNELS];
   logic        chan_active [NUM_CHANNELS];
   logic [15:0] viewer_model;

   voice_result_type pending_results[$];
   int          error_count = 0;
   logic        idle_enabled = 1'b0;
   int          stall_left = 0;
   logic [29:0] paint_time = '0;
   logic [15:0] ent_base = 16'd1;

   voice_channel_allocator #(.DYNAMIC_CHANNELS(NUM_CHANNELS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic voice_result_type predict_voice(input vca_pkg::request_type item);
      voice_result_type   res;
      logic signed [31:0] best;
      logic signed [31:0] life;
      logic             done;
      int               pick;
      res = '{granted: 1'b0, index: 3'd0, count: 4'd0};
      done = 1'b0;
      pick = -1;
      best = vca_pkg::LIFE_START;
      if (item.opcode == vca_pkg::OP_START) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (!done) begin
               if (item.sub_channel != vca_pkg::SUB_NONE && chan_owner[i] == item.entity &&
                   (chan_sub[i] == item.sub_channel ||
                    item.sub_channel == vca_pkg::SUB_ANY)) begin
                  pick = i;
                  done = 1'b1;
               end else if (!(chan_owner[i] == viewer_model &&
                              item.entity != viewer_model && chan_active[i])) begin
                  life = chan_end[i] - 32'(item.now);
                  if (life < best) begin
                     best = life;
                     pick = i;
                  end
               end
            end
         end
         if (pick >= 0) begin
            chan_owner[pick]  = item.entity;
            chan_sub[pick]    = item.sub_channel;
            chan_active[pick] = 1'b1;
            chan_end[pick]    = 32'(item.now) + 32'(item.sound_length);
            res.granted = 1'b1;
            res.index   = 3'(pick);
         end
      end else begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (!done && chan_owner[i] == item.entity &&
                (item.sub_channel == vca_pkg::SUB_NONE || chan_sub[i] == item.sub_channel)) begin
               chan_end[i]    = '0;
               chan_active[i] = 1'b0;
               res.count      = res.count + 4'd1;
               if (item.sub_channel != vca_pkg::SUB_NONE)
                  done = 1'b1;
            end
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // one request transfer; called at a falling edge, returns at a falling edge
   task automatic send_request(input logic op, input logic [15:0] ent,
                               input logic [3:0] sub, input logic [29:0] now,
                               input logic [23:0] len);
      vca_pkg::request_type item;
      item = '{opcode: op, entity: ent, sub_channel: sub, now: now, sound_length: len};
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, len, now, sub, ent};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_voice(item));
      @(negedge clock);
   endtask

   // hold requests until every result is back, then let the pipe settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SCAN_LATENCY) @(negedge clock);
   endtask

   task automatic write_viewer(input logic [15:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      viewer_model = value;
   endtask

   task automatic send_random_request();
      logic        op;
      logic [15:0] ent;
      logic [3:0]  sub;
      logic [23:0] len;
      op = ($urandom_range(0, 3) == 0) ? vca_pkg::OP_STOP : vca_pkg::OP_START;
      case ($urandom_range(0, 9)) inside
         [0:2]:   ent = viewer_model;
         [3:7]:   ent = 16'(ent_base + 16'($urandom_range(0, 3)));
         default: ent = 16'($urandom);
      endcase
      sub = 4'($urandom_range(0, 8) - 1);
      if ($urandom_range(0, 15) == 0)
         paint_time = 30'($urandom);
      else
         paint_time = paint_time + 30'($urandom_range(0, 1 << 18));
      len = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1 << 18));
      send_request(op, ent, sub, paint_time, len);
   endtask

   task automatic test_start_extremes();
      write_viewer(16'h0000);
      send_request(vca_pkg::OP_START, 16'd1, 4'd1, 30'd0, 24'd0);
      send_request(vca_pkg::OP_START, 16'd1, 4'd1, 30'h3FFF_FFFF, 24'hFF_FFFF);
      send_request(vca_pkg::OP_START, 16'd1, vca_pkg::SUB_ANY, 30'd100, 24'd10);
      send_request(vca_pkg::OP_START, 16'd1, vca_pkg::SUB_NONE, 30'd100, 24'd5);
      send_request(vca_pkg::OP_START, 16'd0, 4'd2, 30'd200, 24'd1000);
      send_request(vca_pkg::OP_START, 16'hFFFF, 4'd7, 30'd300, 24'hFF_FFFF);
      send_request(vca_pkg::OP_START, 16'h5A5A, 4'd4, 30'h2AAA_AAAA, 24'hAA_AAAA);
      send_request(vca_pkg::OP_START, 16'hA5A5, 4'd3, 30'h1555_5555, 24'h55_5555);
   endtask

   task automatic test_full_protection();
      write_viewer(16'hFFFF);
      for (int i = 0; i < NUM_CHANNELS; i++)
         send_request(vca_pkg::OP_START, 16'hFFFF, vca_pkg::SUB_NONE, 30'h3000_0000,
                      24'hFF_FFFF);
      send_request(vca_pkg::OP_START, 16'd5, 4'd3, 30'h3000_0001, 24'd20);
      send_request(vca_pkg::OP_START, 16'd5, vca_pkg::SUB_ANY, 30'h3000_0002, 24'd20);
      send_request(vca_pkg::OP_START, 16'hFFFF, vca_pkg::SUB_NONE, 30'h3000_0003, 24'd20);
   endtask

   task automatic test_stop_cases();
      send_request(vca_pkg::OP_STOP, 16'hFFFF, vca_pkg::SUB_NONE, 30'd0, 24'd0);
      send_request(vca_pkg::OP_STOP, 16'hFFFF, vca_pkg::SUB_NONE, 30'd0, 24'd0);
      send_request(vca_pkg::OP_START, 16'd9, vca_pkg::SUB_ANY, 30'd50, 24'd5);
      send_request(vca_pkg::OP_STOP, 16'd9, 4'd3, 30'd60, 24'd0);
      send_request(vca_pkg::OP_STOP, 16'd9, vca_pkg::SUB_ANY, 30'd60, 24'hFF_FFFF);
      send_request(vca_pkg::OP_STOP, 16'd9, vca_pkg::SUB_ANY, 30'd61, 24'd0);
      send_request(vca_pkg::OP_STOP, 16'h1234, 4'd7, 30'h3FFF_FFFF, 24'd0);
   endtask

   task automatic test_random_phases();
      logic [15:0] viewers [4];
      viewers = '{16'h0001, 16'($urandom), 16'hFFFF, 16'h0000};
      for (int p = 0; p < 4; p++) begin
         write_viewer(viewers[p]);
         ent_base = (p == 1) ? viewers[p] : 16'($urandom_range(0, 7));
         idle_enabled = (p != 2) || ($urandom_range(0, 1) == 1);
         for (int n = 0; n < 400; n++) begin
            if (n % 100 == 50)
               idle_enabled = ~idle_enabled;
            send_random_request();
         end
      end
   endtask

   task automatic test_no_idle_tail();
      write_viewer(16'($urandom));
      idle_enabled = 1'b0;
      ent_base = viewer_model - 16'd1;
      repeat (300) send_random_request();
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 16) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      voice_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", {23'b0, rsp_tuser, rsp_tdata}, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.granted)
               report_mismatch("granted", 32'(rsp_tuser), 32'(want.granted));
            if (rsp_tdata[2:0] !== want.index)
               report_mismatch("channel_index", 32'(rsp_tdata[2:0]), 32'(want.index));
            if (rsp_tdata[6:3] !== want.count)
               report_mismatch("stopped_count", 32'(rsp_tdata[6:3]), 32'(want.count));
         end
      end
   end

   initial begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         chan_owner[i]  = '0;
         chan_sub[i]    = '0;
         chan_end[i]    = '0;
         chan_active[i] = 1'b0;
      end
      viewer_model = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_start_extremes();
      test_full_protection();
      test_stop_cases();
      test_random_phases();
      test_no_idle_tail();
      wait_drained();
      repeat (2 * SCAN_LATENCY) @(negedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: voice_channel_allocator.f
hdl/vca_pkg.sv
hdl/vca_cell.sv
hdl/voice_channel_allocator.sv
tb/tb_top.sv
